/* hdl/date_day_difference_core_defines.svh */
// Assertion macros shared by the date day difference checker.
`ifndef DATE_DAY_DIFFERENCE_CORE_DEFINES_SVH
`define DATE_DAY_DIFFERENCE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ddd_pkg.sv */
// Types, constants and table functions of the date day difference core.
package ddd_pkg;

  localparam int OPC_W   = 2;
  localparam int YEAR_W  = 14;
  localparam int MON_W   = 4;
  localparam int DAY_W   = 5;
  localparam int WD_W    = 3;
  localparam int DIST_W  = 22;

  localparam int Q100_W  = 8;
  localparam int R100_W  = 7;
  localparam int CUM_W   = 9;
  localparam int LEN_W   = 5;
  localparam int D7_W    = 8;
  localparam int DAYX_W  = 9;

  // floor(p / 100) = (p * DIV100_MUL) >> DIV100_SH for any 14-bit p
  localparam int DIV100_SH = 19;
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam logic [R100_W-1:0] R100_CENTURY = 7'd99;

  localparam int RES_STAGES = 5;

  typedef enum logic [OPC_W-1:0] {
    OP_DAY_DAY = 2'd0,
    OP_DAY_WK  = 2'd1,
    OP_WK_DAY  = 2'd2,
    OP_WK_WK   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic              wk;
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
    logic [WD_W-1:0]   wday;
  } date_t;

  function automatic int dn_width(int year_max);
    int yeff;
    yeff = (year_max > (2**YEAR_W - 1)) ? (2**YEAR_W - 1) : year_max;
    return $clog2(yeff * 366 + 1);
  endfunction

  function automatic logic [CUM_W-1:0] cum_days(logic [MON_W-1:0] m);
    logic [CUM_W-1:0] c;
    unique case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  function automatic logic [LEN_W-1:0] month_len(logic [MON_W-1:0] m);
    logic [LEN_W-1:0] l;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                  l = 5'd30;
      4'd2:                                     l = 5'd28;
      default:                                  l = 5'd0;
    endcase
    return l;
  endfunction

  // Residue mod 7 by folding octal digits (8 = 1 mod 7).
  function automatic logic [2:0] mod7(logic [31:0] v);
    logic [32:0] x;
    logic [6:0]  s;
    logic [3:0]  t;
    logic [3:0]  u;
    x = {1'b0, v};
    s = '0;
    for (int i = 0; i < 11; i++) begin
      s = s + 7'(x[3*i +: 3]);
    end
    t = 4'(s[2:0]) + 4'(s[5:3]) + 4'(s[6]);
    u = 4'(t[2:0]) + 4'(t[3]);
    return (u >= 4'd7) ? 3'(u - 4'd7) : 3'(u);
  endfunction

endpackage

/* hdl/ddd_if.sv */
// Valid/ready channel interfaces for the date day difference core.
interface ddd_in_if;
  logic                         valid;
  logic                         ready;
  logic [ddd_pkg::OPC_W-1:0]    opcode;
  logic [ddd_pkg::YEAR_W-1:0]   year_a;
  logic [ddd_pkg::MON_W-1:0]    month_a;
  logic [ddd_pkg::DAY_W-1:0]    day_or_nth_a;
  logic [ddd_pkg::WD_W-1:0]     weekday_a;
  logic [ddd_pkg::YEAR_W-1:0]   year_b;
  logic [ddd_pkg::MON_W-1:0]    month_b;
  logic [ddd_pkg::DAY_W-1:0]    day_or_nth_b;
  logic [ddd_pkg::WD_W-1:0]     weekday_b;

  modport source (
    output valid, opcode, year_a, month_a, day_or_nth_a, weekday_a,
           year_b, month_b, day_or_nth_b, weekday_b,
    input  ready
  );
  modport sink (
    input  valid, opcode, year_a, month_a, day_or_nth_a, weekday_a,
           year_b, month_b, day_or_nth_b, weekday_b,
    output ready
  );
endinterface

interface ddd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         invalid;
  logic [ddd_pkg::DIST_W-1:0]   day_distance;

  modport source (output valid, invalid, day_distance, input ready);
  modport sink (input valid, invalid, day_distance, output ready);
endinterface

/* hdl/ddd_resolve.sv */
// Five-stage pipeline that turns one date into its day number and a validity flag.
module ddd_resolve #(
  parameter int YEAR_MAX = 9999
) (
  input  logic                              clk,
  input  logic [ddd_pkg::RES_STAGES-1:0]    en,
  input  ddd_pkg::date_t                    date,
  output logic [ddd_pkg::dn_width(YEAR_MAX)-1:0] num,
  output logic                              ok
);

  localparam int DN_W   = ddd_pkg::dn_width(YEAR_MAX);
  localparam int YW     = ddd_pkg::YEAR_W;
  localparam int PROD_W = YW + 13;
  localparam int P365_W = YW + 9;

  // stage 1
  logic [YW-1:0]               s1_p_r;
  logic [ddd_pkg::Q100_W-1:0]  s1_q100_r;
  logic [DN_W-1:0]             s1_p365_r;
  logic [ddd_pkg::CUM_W-1:0]   s1_cum_r;
  logic [ddd_pkg::LEN_W-1:0]   s1_len_r;
  logic                        s1_gt2_r, s1_feb_r, s1_ok_r, s1_wk_r;
  logic [1:0]                  s1_y2_r;
  logic [ddd_pkg::DAY_W-1:0]   s1_d_r;
  logic [ddd_pkg::WD_W-1:0]    s1_w_r;

  logic [YW-1:0]     p;
  logic [PROD_W-1:0] q_prod;
  logic              yr_ok, mon_ok, fld_ok;

  always_comb begin
    p      = date.year - YW'(1);
    q_prod = PROD_W'(p) * PROD_W'(ddd_pkg::DIV100_MUL);
    yr_ok  = (date.year != '0) && (32'(date.year) <= YEAR_MAX);
    mon_ok = (date.month >= 4'd1) && (date.month <= 4'd12);
    fld_ok = (date.day != '0) && (!date.wk || (date.wday <= 3'd6));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_p_r    <= p;
      s1_q100_r <= q_prod[ddd_pkg::DIV100_SH +: ddd_pkg::Q100_W];
      s1_p365_r <= DN_W'(P365_W'(p) * P365_W'(365));
      s1_cum_r  <= ddd_pkg::cum_days(date.month);
      s1_len_r  <= ddd_pkg::month_len(date.month);
      s1_gt2_r  <= (date.month > 4'd2);
      s1_feb_r  <= (date.month == 4'd2);
      s1_ok_r   <= yr_ok && mon_ok && fld_ok;
      s1_wk_r   <= date.wk;
      s1_y2_r   <= date.year[1:0];
      s1_d_r    <= date.day;
      s1_w_r    <= date.wday;
    end
  end

  // stage 2: remainder mod 100 and the leap-free part of the base
  logic [ddd_pkg::R100_W-1:0]  s2_r100_r;
  logic [DN_W-1:0]             s2_part_r;
  logic [1:0]                  s2_q2_r, s2_y2_r;
  logic [ddd_pkg::LEN_W-1:0]   s2_len_r;
  logic                        s2_gt2_r, s2_feb_r, s2_ok_r, s2_wk_r;
  logic [ddd_pkg::DAY_W-1:0]   s2_d_r;
  logic [ddd_pkg::WD_W-1:0]    s2_w_r;

  logic [YW-1:0] r100_full;
  assign r100_full = s1_p_r - (YW'(s1_q100_r) * YW'(100));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_r100_r <= r100_full[ddd_pkg::R100_W-1:0];
      s2_part_r <= s1_p365_r + DN_W'(s1_p_r >> 2) - DN_W'(s1_q100_r)
                 + DN_W'(s1_q100_r >> 2) + DN_W'(s1_cum_r);
      s2_q2_r   <= s1_q100_r[1:0];
      s2_y2_r   <= s1_y2_r;
      s2_len_r  <= s1_len_r;
      s2_gt2_r  <= s1_gt2_r;
      s2_feb_r  <= s1_feb_r;
      s2_ok_r   <= s1_ok_r;
      s2_wk_r   <= s1_wk_r;
      s2_d_r    <= s1_d_r;
      s2_w_r    <= s1_w_r;
    end
  end

  // stage 3: leap year correction
  logic [DN_W-1:0]             s3_base_r;
  logic [ddd_pkg::LEN_W-1:0]   s3_len_r;
  logic                        s3_ok_r, s3_wk_r;
  logic [ddd_pkg::DAY_W-1:0]   s3_d_r;
  logic [ddd_pkg::WD_W-1:0]    s3_w_r;

  logic leap;
  assign leap = (s2_y2_r == 2'd0) &&
                ((s2_r100_r != ddd_pkg::R100_CENTURY) || (s2_q2_r == 2'd3));

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_base_r <= s2_part_r + DN_W'(s2_gt2_r && leap);
      s3_len_r  <= s2_len_r + ddd_pkg::LEN_W'(s2_feb_r && leap);
      s3_ok_r   <= s2_ok_r;
      s3_wk_r   <= s2_wk_r;
      s3_d_r    <= s2_d_r;
      s3_w_r    <= s2_w_r;
    end
  end

  // stage 4: weekday of the first of the month
  logic [DN_W-1:0]             s4_base_r;
  logic [ddd_pkg::LEN_W-1:0]   s4_len_r;
  logic                        s4_ok_r, s4_wk_r;
  logic [ddd_pkg::DAY_W-1:0]   s4_d_r;
  logic [ddd_pkg::WD_W-1:0]    s4_w_r;
  logic [2:0]                  s4_wd1_r;
  logic [ddd_pkg::D7_W-1:0]    s4_d7_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_base_r <= s3_base_r;
      s4_len_r  <= s3_len_r;
      s4_ok_r   <= s3_ok_r;
      s4_wk_r   <= s3_wk_r;
      s4_d_r    <= s3_d_r;
      s4_w_r    <= s3_w_r;
      s4_wd1_r  <= ddd_pkg::mod7(32'(s3_base_r));
      s4_d7_r   <= (ddd_pkg::D7_W'(s3_d_r) - 8'd1) * 8'd7;
    end
  end

  // stage 5: day within month, range check, day number
  logic [3:0]                  wk_t;
  logic [2:0]                  wk_off;
  logic [ddd_pkg::DAYX_W-1:0]  day_x;

  always_comb begin
    wk_t   = 4'(s4_w_r) + 4'd7 - 4'(s4_wd1_r);
    wk_off = (wk_t >= 4'd7) ? 3'(wk_t - 4'd7) : 3'(wk_t);
    if (s4_wk_r) begin
      day_x = 9'd1 + 9'(wk_off) + 9'(s4_d7_r);
    end else begin
      day_x = 9'(s4_d_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      num <= s4_base_r + DN_W'(day_x);
      ok  <= s4_ok_r && (day_x <= 9'(s4_len_r));
    end
  end

endmodule

/* hdl/date_day_difference_core.sv */
// Top level: absolute day distance between two Gregorian dates, fully pipelined.
//
//   channel   dir  fields                                             flow
//   in_ch     in   opcode, year/month/day_or_nth/weekday for a and b  valid/ready
//   out_ch    out  invalid, day_distance                              valid/ready
//
// One beat per cycle sustained while out_ch.ready stays high.
// Depth is set by the input register, the five-stage date resolve pipeline
// (divide by 100, base sum, leap fix, mod 7, day check) and the result register.
// rst_n (synchronous, active low) clears the stage valid bits only.
// With out_ch.ready low the result holds and earlier stages keep filling any
// empty slots; in_ch.ready drops only once every stage holds a beat.
module date_day_difference_core #(
  parameter int YEAR_MAX = 9999
) (
  input  logic             clk,
  input  logic             rst_n,
  ddd_in_if.sink           in_ch,
  ddd_out_if.source        out_ch
);

  localparam int DN_W = ddd_pkg::dn_width(YEAR_MAX);
  localparam int NSTG = ddd_pkg::RES_STAGES + 2;

  logic [NSTG-1:0] vld_r, vld_nxt, load;

  always_comb begin
    load[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG-2; k >= 0; k--) begin
      load[k] = !vld_r[k] || load[k+1];
    end
    vld_nxt[0] = load[0] ? in_ch.valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = load[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // input register
  ddd_pkg::opcode_t s0_opc_r;
  ddd_pkg::date_t   s0_a_r, s0_b_r;
  ddd_pkg::date_t   date_a, date_b;
  logic             wk_a, wk_b;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s0_opc_r     <= ddd_pkg::opcode_t'(in_ch.opcode);
      s0_a_r.wk    <= 1'b0;
      s0_a_r.year  <= in_ch.year_a;
      s0_a_r.month <= in_ch.month_a;
      s0_a_r.day   <= in_ch.day_or_nth_a;
      s0_a_r.wday  <= in_ch.weekday_a;
      s0_b_r.wk    <= 1'b0;
      s0_b_r.year  <= in_ch.year_b;
      s0_b_r.month <= in_ch.month_b;
      s0_b_r.day   <= in_ch.day_or_nth_b;
      s0_b_r.wday  <= in_ch.weekday_b;
    end
  end

  always_comb begin
    unique case (s0_opc_r)
      ddd_pkg::OP_DAY_DAY: begin wk_a = 1'b0; wk_b = 1'b0; end
      ddd_pkg::OP_DAY_WK:  begin wk_a = 1'b0; wk_b = 1'b1; end
      ddd_pkg::OP_WK_DAY:  begin wk_a = 1'b1; wk_b = 1'b0; end
      ddd_pkg::OP_WK_WK:   begin wk_a = 1'b1; wk_b = 1'b1; end
      default:             begin wk_a = 1'b0; wk_b = 1'b0; end
    endcase
    date_a    = s0_a_r;
    date_a.wk = wk_a;
    date_b    = s0_b_r;
    date_b.wk = wk_b;
  end

  logic [DN_W-1:0] num_a, num_b;
  logic            ok_a, ok_b;

  ddd_resolve #(.YEAR_MAX(YEAR_MAX)) u_res_a (
    .clk  (clk),
    .en   (load[ddd_pkg::RES_STAGES:1]),
    .date (date_a),
    .num  (num_a),
    .ok   (ok_a)
  );

  ddd_resolve #(.YEAR_MAX(YEAR_MAX)) u_res_b (
    .clk  (clk),
    .en   (load[ddd_pkg::RES_STAGES:1]),
    .date (date_b),
    .num  (num_b),
    .ok   (ok_b)
  );

  // result register
  logic                      out_invalid_r;
  logic [ddd_pkg::DIST_W-1:0] out_dist_r;
  logic [DN_W-1:0]           diff;

  assign diff = (num_a > num_b) ? (num_a - num_b) : (num_b - num_a);

  always_ff @(posedge clk) begin
    if (load[NSTG-1]) begin
      out_invalid_r <= !(ok_a && ok_b);
      out_dist_r    <= (ok_a && ok_b) ? ddd_pkg::DIST_W'(diff) : '0;
    end
  end

  assign in_ch.ready         = load[0];
  assign out_ch.valid        = vld_r[NSTG-1];
  assign out_ch.invalid      = out_invalid_r;
  assign out_ch.day_distance = out_dist_r;

endmodule

/* hdl/ddd_chk.sv */
// Port-level assertion checker for the date day difference core, with its bind.
`include "date_day_difference_core_defines.svh"

module ddd_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_invalid,
  input logic [ddd_pkg::DIST_W-1:0]  out_dist
);

  `DDD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
  `DDD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_invalid) && $stable(out_dist), "stalled result changed")
  `DDD_ASSERT_NOW(a_inv_zero, out_valid && out_invalid, out_dist == '0, "invalid result with nonzero distance")
  `DDD_ASSERT_NOW(a_ready_free, !out_valid || out_ready, in_ready, "input stalled though result side is free")
  `DDD_ASSERT_NOW(a_rst_empty, $rose(rst_n), !out_valid, "result valid right after reset")

endmodule

bind date_day_difference_core ddd_chk u_ddd_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_invalid (out_ch.invalid),
  .out_dist    (out_ch.day_distance)
);
